FILE: hdl/layer_z_order_manager_assert.svh
// assertion macros used by the layer z-order manager datapath
// expects clk and rst_n in the scope of each use
`ifndef LAYER_Z_ORDER_MANAGER_ASSERT_SVH
`define LAYER_Z_ORDER_MANAGER_ASSERT_SVH

`ifndef ASSERT_OFF

// condition implies property in the same cycle
`define LZO_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("lzo assertion failed");

// property holds on every enabled cycle
`define LZO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lzo assertion failed");

`else

`define LZO_ASSERT_IMP(lbl, cond, prop)
`define LZO_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: hdl/lzo_pkg.sv
// shared types and constants for the layer z-order manager
// no dependencies
package lzo_pkg;

  // fixed field widths of the words
  localparam int REQ_W    = 2;
  localparam int LAYER_W  = 8;
  localparam int WANT_W   = 10;
  localparam int HEIGHT_W = 9;

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic scan;
    logic decide;
    logic step;
    logic place;
    logic load_out;
  } lzo_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
    logic scan_hit;
    logic scan_miss;
    logic steps_zero;
    logic wr_pend;
    logic out_free;
    logic req_alloc;
    logic req_move;
  } lzo_status_t;

endpackage

FILE: hdl/lzo_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lzo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/lzo_ctrl.sv
// controller state machine for the layer z-order manager
// depends on lzo_pkg for the command and status structs
module lzo_ctrl
  import lzo_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output lzo_cmd_t    cmd_o,
  input  lzo_status_t status_i
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_LOOKUP = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_SHIFT  = 8'b0010_0000,
    S_PLACE  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // state register, clearing pass first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        // layer entry read is under way, pick the path
        if (status_i.req_alloc) begin
          state_nxt = S_SCAN;
        end else if (status_i.req_move) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_hit || status_i.scan_miss) begin
          state_nxt = S_DONE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.step = 1'b1;
        if (status_i.steps_zero && !status_i.wr_pend) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

FILE: hdl/lzo_datapath.sv
// datapath of the layer z-order manager: layer and order rams, shift pipeline,
// free layer scan, result and output registers; depends on lzo_pkg and lzo_ram
`include "layer_z_order_manager_assert.svh"

module lzo_datapath
  import lzo_pkg::*;
#(
  parameter int NUM_LAYERS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [REQ_W-1:0]           in_req_type,
  input  logic [LAYER_W-1:0]         in_layer_id,
  input  logic signed [WANT_W-1:0]   in_wanted_height,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic [LAYER_W-1:0]         out_result_layer,
  output logic signed [HEIGHT_W-1:0] out_applied_height,
  output logic signed [HEIGHT_W-1:0] out_top_index,
  output logic                       out_redraw_needed,
  input  lzo_cmd_t                   cmd_i,
  output lzo_status_t                status_o
);

  localparam int LW  = $clog2(NUM_LAYERS);
  localparam int HB  = LW + 1;
  localparam int IDW = (LW > LAYER_W) ? LW : LAYER_W;
  localparam int CW  = ((HB > WANT_W) ? HB : WANT_W) + 1;
  localparam int LRW = HB + 1;

  localparam logic signed [HB-1:0] H_ONE  = HB'(1);
  localparam logic signed [HB-1:0] H_NEG1 = '1;
  localparam logic [LW:0]          CNT_END  = (LW+1)'(NUM_LAYERS);
  localparam logic [LW:0]          CNT_LAST = (LW+1)'(NUM_LAYERS - 1);
  localparam logic [LW-1:0]        ADDR_LAST = LW'(NUM_LAYERS - 1);

  // request registers
  logic [REQ_W-1:0]         req_r;
  logic [LW-1:0]            id_r;
  logic                     in_range_r;
  logic signed [WANT_W-1:0] want_r;

  // sweep counter, scan pipeline
  logic [LW:0]   cnt_r;
  logic          scan_v_r;
  logic [LW-1:0] scan_addr_r;

  // shift pipeline
  logic signed [HB-1:0] src_r;
  logic                 up_r;
  logic [LW:0]          steps_r;
  logic                 wr_pend_r;
  logic signed [HB-1:0] wr_dst_r;
  logic signed [HB-1:0] tgt_r;
  logic                 place_r;
  logic signed [HB-1:0] top_r;

  // result registers
  logic                       res_status_r;
  logic [LAYER_W-1:0]         res_layer_r;
  logic signed [HEIGHT_W-1:0] res_applied_r;
  logic                       res_redraw_r;

  // output register
  logic                       out_valid_r;
  logic                       out_status_r;
  logic [LAYER_W-1:0]         out_layer_r;
  logic signed [HEIGHT_W-1:0] out_applied_r;
  logic signed [HEIGHT_W-1:0] out_top_r;
  logic                       out_redraw_r;

  // ram ports
  logic           lr_we;
  logic [LW-1:0]  lr_waddr;
  logic [LRW-1:0] lr_wdata;
  logic [LW-1:0]  lr_raddr;
  logic [LRW-1:0] lr_rdata;
  logic           ot_we;
  logic [LW-1:0]  ot_waddr;
  logic [LW-1:0]  ot_wdata;
  logic [LW-1:0]  ot_raddr;
  logic [LW-1:0]  ot_rdata;

  // decode and decision signals
  logic [IDW:0]         id_ext;
  logic [IDW-1:0]       scan_layer_ext;
  logic                 lr_in_use;
  logic signed [HB-1:0] lr_old;
  logic signed [HB-1:0] limit;
  logic signed [CW-1:0] want_c;
  logic signed [CW-1:0] limit_c;
  logic signed [HB-1:0] tgt_set;
  logic signed [HB-1:0] tgt;
  logic                 valid_op;
  logic                 change;
  logic signed [HB-1:0] mv_src;
  logic                 mv_up;
  logic signed [HB-1:0] mv_steps;
  logic                 mv_top_inc;
  logic                 mv_top_dec;
  logic                 scan_hit;
  logic                 scan_miss;
  logic                 cnt_end;
  logic                 step_go;

  lzo_ram #(.WIDTH(LRW), .DEPTH(NUM_LAYERS)) u_layer_ram (
    .clk   (clk),
    .we    (lr_we),
    .waddr (lr_waddr),
    .wdata (lr_wdata),
    .raddr (lr_raddr),
    .rdata (lr_rdata)
  );

  lzo_ram #(.WIDTH(LW), .DEPTH(NUM_LAYERS)) u_order_ram (
    .clk   (clk),
    .we    (ot_we),
    .waddr (ot_waddr),
    .wdata (ot_wdata),
    .raddr (ot_raddr),
    .rdata (ot_rdata)
  );

  // input decode
  assign id_ext         = (IDW+1)'(in_layer_id);
  assign scan_layer_ext = IDW'(scan_addr_r);
  assign lr_in_use      = lr_rdata[LRW-1];
  assign lr_old         = lr_rdata[HB-1:0];

  // scan status
  assign cnt_end   = (cnt_r == CNT_END);
  assign scan_hit  = scan_v_r && !lr_in_use;
  assign scan_miss = scan_v_r && lr_in_use && (scan_addr_r == ADDR_LAST);
  assign step_go   = cmd_i.step && (steps_r != '0);

  // clamp of the wanted height, a shown layer cannot rise above the top
  always_comb begin
    limit   = (lr_old >= 0) ? top_r : top_r + H_ONE;
    want_c  = CW'(want_r);
    limit_c = CW'(limit);
    if (want_c > limit_c) begin
      tgt_set = limit;
    end else if (want_c < CW'(H_NEG1)) begin
      tgt_set = H_NEG1;
    end else begin
      tgt_set = HB'(want_c);
    end
    tgt      = (req_r == REQ_FREE) ? H_NEG1 : tgt_set;
    valid_op = in_range_r && lr_in_use;
    change   = (lr_old != tgt);
  end

  // shift plan: first source, direction and number of moved entries
  always_comb begin
    mv_src     = top_r;
    mv_up      = 1'b0;
    mv_steps   = '0;
    mv_top_inc = 1'b0;
    mv_top_dec = 1'b0;
    if (lr_old > tgt) begin
      if (tgt >= 0) begin
        // lowering: entries between slide up by one
        mv_src   = lr_old - H_ONE;
        mv_up    = 1'b0;
        mv_steps = lr_old - tgt;
      end else begin
        // hiding: close the gap above
        mv_src     = lr_old + H_ONE;
        mv_up      = 1'b1;
        mv_steps   = top_r - lr_old;
        mv_top_dec = 1'b1;
      end
    end else if (lr_old < tgt) begin
      if (lr_old >= 0) begin
        // raising: entries between slide down by one
        mv_src   = lr_old + H_ONE;
        mv_up    = 1'b1;
        mv_steps = tgt - lr_old;
      end else begin
        // showing: open a gap at the target
        mv_src     = top_r;
        mv_up      = 1'b0;
        mv_steps   = top_r - tgt + H_ONE;
        mv_top_inc = 1'b1;
      end
    end
  end

  // layer ram port selection
  always_comb begin
    lr_we    = 1'b0;
    lr_waddr = id_r;
    lr_wdata = {1'b1, H_NEG1};
    if (cmd_i.clear) begin
      lr_we    = 1'b1;
      lr_waddr = cnt_r[LW-1:0];
      lr_wdata = {1'b0, H_NEG1};
    end else if (cmd_i.scan && scan_hit) begin
      lr_we    = 1'b1;
      lr_waddr = scan_addr_r;
      lr_wdata = {1'b1, H_NEG1};
    end else if (cmd_i.decide && valid_op) begin
      lr_we    = 1'b1;
      lr_waddr = id_r;
      lr_wdata = {(req_r == REQ_SET), tgt};
    end else if (wr_pend_r) begin
      lr_we    = 1'b1;
      lr_waddr = ot_rdata;
      lr_wdata = {1'b1, wr_dst_r};
    end
    lr_raddr = cmd_i.scan ? cnt_r[LW-1:0] : id_r;
  end

  // order ram port selection
  always_comb begin
    ot_we    = 1'b0;
    ot_waddr = wr_dst_r[LW-1:0];
    ot_wdata = ot_rdata;
    if (wr_pend_r) begin
      ot_we = 1'b1;
    end else if (cmd_i.place && place_r) begin
      ot_we    = 1'b1;
      ot_waddr = tgt_r[LW-1:0];
      ot_wdata = id_r;
    end
    ot_raddr = src_r[LW-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      scan_v_r    <= 1'b0;
      steps_r     <= '0;
      wr_pend_r   <= 1'b0;
      place_r     <= 1'b0;
      top_r       <= H_NEG1;
      out_valid_r <= 1'b0;
    end else begin
      // sweep counter for clearing and scanning
      if (cmd_i.capture) begin
        cnt_r <= '0;
      end else if (cmd_i.clear || (cmd_i.scan && !cnt_end)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      scan_v_r  <= cmd_i.scan && !cnt_end && !scan_hit;
      wr_pend_r <= step_go;
      // shift plan taken on decision
      if (cmd_i.decide) begin
        steps_r <= (valid_op && change) ? $unsigned(mv_steps) : '0;
        place_r <= valid_op && change && (tgt >= 0);
        if (valid_op && mv_top_inc) begin
          top_r <= top_r + H_ONE;
        end else if (valid_op && mv_top_dec) begin
          top_r <= top_r - H_ONE;
        end
      end else if (step_go) begin
        steps_r <= steps_r - 1'b1;
      end
      // output word valid
      if (cmd_i.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      req_r         <= in_req_type;
      id_r          <= id_ext[LW-1:0];
      in_range_r    <= (id_ext < (IDW+1)'(NUM_LAYERS));
      want_r        <= in_wanted_height;
      res_status_r  <= (in_req_type == REQ_ALLOC);
      res_layer_r   <= ((in_req_type == REQ_SET) || (in_req_type == REQ_FREE)) ?
                       in_layer_id : '0;
      res_applied_r <= '1;
      res_redraw_r  <= 1'b0;
    end
    if (cmd_i.scan) begin
      scan_addr_r <= cnt_r[LW-1:0];
    end
    if (cmd_i.scan && scan_hit) begin
      res_status_r <= 1'b0;
      res_layer_r  <= scan_layer_ext[LAYER_W-1:0];
    end
    if (cmd_i.decide) begin
      src_r         <= mv_src;
      up_r          <= mv_up;
      tgt_r         <= tgt;
      res_applied_r <= valid_op ? HEIGHT_W'(tgt) : '1;
      res_redraw_r  <= valid_op && change;
    end else if (step_go) begin
      src_r <= up_r ? src_r + H_ONE : src_r - H_ONE;
    end
    if (step_go) begin
      wr_dst_r <= up_r ? src_r - H_ONE : src_r + H_ONE;
    end
    if (cmd_i.load_out) begin
      out_status_r  <= res_status_r;
      out_layer_r   <= res_layer_r;
      out_applied_r <= res_applied_r;
      out_top_r     <= HEIGHT_W'(top_r);
      out_redraw_r  <= res_redraw_r;
    end
  end

  // status to the controller
  always_comb begin
    status_o            = '0;
    status_o.clear_last = (cnt_r == CNT_LAST);
    status_o.scan_hit   = scan_hit;
    status_o.scan_miss  = scan_miss;
    status_o.steps_zero = (steps_r == '0);
    status_o.wr_pend    = wr_pend_r;
    status_o.out_free   = !out_valid_r || !out_stall;
    status_o.req_alloc  = (req_r == REQ_ALLOC);
    status_o.req_move   = (req_r == REQ_SET) || (req_r == REQ_FREE);
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_layer   = out_layer_r;
  assign out_applied_height = out_applied_r;
  assign out_top_index      = out_top_r;
  assign out_redraw_needed  = out_redraw_r;

  // placing the layer must not collide with a pending shift write
  `LZO_ASSERT_IMP(a_place_no_shift, cmd_i.place, !wr_pend_r)
  // a result is only loaded once the shift pipeline has drained
  `LZO_ASSERT_IMP(a_load_drained, cmd_i.load_out, (steps_r == '0) && !wr_pend_r)
  // the top never drops below the empty marker
  `LZO_ASSERT_ALWAYS(a_top_floor, top_r >= H_NEG1)

endmodule

FILE: hdl/layer_z_order_manager.sv
// layer z-order manager: keeps a pool of NUM_LAYERS display layers and their
// stacking order. Input words carry a request (allocate, set height, free), a
// layer and a wanted height; each input word yields exactly one output word
// with status, layer, applied height, top index and a redraw flag.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Operation: one request is worked on at a time. An allocate scans the layer ram
// one entry a cycle up to j, the lowest free layer. A set-height or free shifts
// k order table entries (at most NUM_LAYERS - 1), one entry a cycle through the
// order ram read and write ports.
// The output register lets the next request be taken while a result still
// waits; a stalled output word holds, and the next result waits behind it.
// After reset a clearing pass over all NUM_LAYERS entries marks every layer free;
// in_stall is high throughout it.
// Depends on lzo_pkg, lzo_ctrl, lzo_datapath and lzo_ram.
module layer_z_order_manager
  import lzo_pkg::*;
#(
  parameter int NUM_LAYERS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [REQ_W-1:0]           in_req_type,
  input  logic [LAYER_W-1:0]         in_layer_id,
  input  logic signed [WANT_W-1:0]   in_wanted_height,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic [LAYER_W-1:0]         out_result_layer,
  output logic signed [HEIGHT_W-1:0] out_applied_height,
  output logic signed [HEIGHT_W-1:0] out_top_index,
  output logic                       out_redraw_needed
);

  lzo_cmd_t    cmd;
  lzo_status_t status;

  // sequencing
  lzo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd_o    (cmd),
    .status_i (status)
  );

  // storage and arithmetic
  lzo_datapath #(.NUM_LAYERS(NUM_LAYERS)) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_req_type        (in_req_type),
    .in_layer_id        (in_layer_id),
    .in_wanted_height   (in_wanted_height),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_layer   (out_result_layer),
    .out_applied_height (out_applied_height),
    .out_top_index      (out_top_index),
    .out_redraw_needed  (out_redraw_needed),
    .cmd_i              (cmd),
    .status_o           (status)
  );

endmodule

FILE: tb/layer_z_order_manager_tb.sv
// self-checking testbench for layer_z_order_manager: directed table then random requests,
// every result word checked against fixed table words or a stacking-order predictor
// depends on lzo_pkg and layer_z_order_manager
module layer_z_order_manager_tb
  import lzo_pkg::*;
();

  localparam int LAYERS = 256;
  localparam int PLAN_LEN = 21;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int IDLE_PCT = 24;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic signed [HEIGHT_W-1:0] HIDDEN = -9'sd1;

  typedef struct packed {
    logic                       status;
    logic [LAYER_W-1:0]         layer;
    logic signed [HEIGHT_W-1:0] applied;
    logic signed [HEIGHT_W-1:0] top;
    logic                       redraw;
  } stack_report_t;

  typedef struct {
    logic [REQ_W-1:0]         req;
    logic [LAYER_W-1:0]       id;
    logic signed [WANT_W-1:0] want;
    bit                       typed;
    stack_report_t            report;
  } plan_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [REQ_W-1:0]           in_req_type;
  logic [LAYER_W-1:0]         in_layer_id;
  logic signed [WANT_W-1:0]   in_wanted_height;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_status;
  logic [LAYER_W-1:0]         out_result_layer;
  logic signed [HEIGHT_W-1:0] out_applied_height;
  logic signed [HEIGHT_W-1:0] out_top_index;
  logic                       out_redraw_needed;

  // predictor copy of the layer pool and stacking order
  bit pool_busy [LAYERS];
  int lyr_height [LAYERS];
  int stack_at [LAYERS];
  int top_h = -1;

  stack_report_t reports_due [$];
  plan_row_t     plan [PLAN_LEN];
  int            errors = 0;
  int            hold_asked = 0;
  int            hold_done = 0;
  bit            no_idle = 1'b0;

  layer_z_order_manager #(
    .NUM_LAYERS(LAYERS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_layer_id       (in_layer_id),
    .in_wanted_height  (in_wanted_height),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_layer  (out_result_layer),
    .out_applied_height(out_applied_height),
    .out_top_index     (out_top_index),
    .out_redraw_needed (out_redraw_needed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int lowest_free();
    for (int k = 0; k < LAYERS; k++) begin
      if (!pool_busy[k]) return k;
    end
    return -1;
  endfunction

  // clamp and move one layer, shifting the layers in between; 1 if order changed
  function automatic bit restack(int id, int want, output int applied);
    int old;
    int limit;
    int h;
    old = lyr_height[id];
    limit = (old >= 0) ? top_h : top_h + 1;
    if (want > limit) want = limit;
    if (want < -1) want = -1;
    lyr_height[id] = want;
    applied = want;
    if (old > want) begin
      if (want >= 0) begin
        for (h = old; h > want; h--) begin
          stack_at[h] = stack_at[h - 1];
          lyr_height[stack_at[h]] = h;
        end
        stack_at[want] = id;
      end else begin
        // hiding closes the gap above the old place
        for (h = old; h < top_h; h++) begin
          stack_at[h] = stack_at[h + 1];
          lyr_height[stack_at[h]] = h;
        end
        top_h--;
      end
    end else if (old < want) begin
      if (old >= 0) begin
        for (h = old; h < want; h++) begin
          stack_at[h] = stack_at[h + 1];
          lyr_height[stack_at[h]] = h;
        end
        stack_at[want] = id;
      end else begin
        // showing opens a gap at the new place
        for (h = top_h; h >= want; h--) begin
          stack_at[(h + 1) % LAYERS] = stack_at[h];
          lyr_height[stack_at[h]] = h + 1;
        end
        stack_at[want] = id;
        top_h++;
      end
    end
    return old != want;
  endfunction

  // expected result word of one request, updating the predictor state
  function automatic stack_report_t predict_stacking(logic [REQ_W-1:0] req,
                                                     logic [LAYER_W-1:0] id,
                                                     logic signed [WANT_W-1:0] want);
    stack_report_t rep;
    int applied;
    int slot_i;
    rep = '0;
    applied = -1;
    if (req == REQ_ALLOC) begin
      slot_i = lowest_free();
      if (slot_i < 0) begin
        rep.status = 1'b1;
      end else begin
        pool_busy[slot_i] = 1'b1;
        lyr_height[slot_i] = -1;
        rep.layer = slot_i[LAYER_W-1:0];
      end
    end else if (req == REQ_SET || req == REQ_FREE) begin
      rep.layer = id;
      if (pool_busy[id]) begin
        if (req == REQ_SET) begin
          rep.redraw = restack(int'(id), int'(want), applied);
        end else begin
          if (lyr_height[id] >= 0) rep.redraw = restack(int'(id), -1, applied);
          pool_busy[id] = 1'b0;
        end
      end
    end
    rep.applied = applied[HEIGHT_W-1:0];
    rep.top = top_h[HEIGHT_W-1:0];
    return rep;
  endfunction

  // random layer that is in use, or any layer if none is
  function automatic logic [LAYER_W-1:0] pick_busy();
    int n;
    int k;
    n = 0;
    for (int i = 0; i < LAYERS; i++) n += pool_busy[i];
    if (n == 0) return LAYER_W'($urandom_range(LAYERS - 1));
    k = $urandom_range(n - 1);
    for (int i = 0; i < LAYERS; i++) begin
      if (pool_busy[i]) begin
        if (k == 0) return i[LAYER_W-1:0];
        k--;
      end
    end
    return '0;
  endfunction

  // mostly heights in the useful range, with hides and far out-of-range values
  function automatic logic signed [WANT_W-1:0] pick_height();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 55) v = int'($urandom_range(top_h + 2, 0)) - 1;
    else if (r < 65) v = -1;
    else if (r < 80) v = $urandom_range(511, 0);
    else if (r < 90) v = -int'($urandom_range(512, 1));
    else v = int'($urandom_range(1023, 0)) - 512;
    return v[WANT_W-1:0];
  endfunction

  // offer one request word and queue its expected result once taken
  task automatic offer_word(input logic [REQ_W-1:0] req, input logic [LAYER_W-1:0] id,
                            input logic signed [WANT_W-1:0] want,
                            input bit typed = 1'b0, input stack_report_t fixed_rep = '0);
    stack_report_t rep;
    bit taken;
    rep = predict_stacking(req, id, want);
    if (typed) rep = fixed_rep;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_layer_id <= id;
    in_wanted_height <= want;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    reports_due.push_back(rep);
  endtask

  // sender stops until every expected word has come back
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int r;
    int slot_i;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= REQ_ALLOC;
    in_layer_id <= '0;
    in_wanted_height <= '0;

    // directed table: ignored requests, first allocations, clamps, moves, frees
    plan[0]  = '{REQ_SET,    8'd0,   10'sd0,    1'b1, '{1'b0, 8'd0, HIDDEN, HIDDEN, 1'b0}};
    plan[1]  = '{REQ_FREE,   8'd255, -10'sd1,   1'b1, '{1'b0, 8'd255, HIDDEN, HIDDEN, 1'b0}};
    plan[2]  = '{REQ_UNUSED, 8'hAA,  10'sd511,  1'b1, '{1'b0, 8'd0, HIDDEN, HIDDEN, 1'b0}};
    plan[3]  = '{REQ_ALLOC,  8'd0,   10'sd0,    1'b1, '{1'b0, 8'd0, HIDDEN, HIDDEN, 1'b0}};
    plan[4]  = '{REQ_ALLOC,  8'd0,   10'sd0,    1'b1, '{1'b0, 8'd1, HIDDEN, HIDDEN, 1'b0}};
    plan[5]  = '{REQ_ALLOC,  8'd255, -10'sd512, 1'b1, '{1'b0, 8'd2, HIDDEN, HIDDEN, 1'b0}};
    plan[6]  = '{REQ_SET,    8'd0,   10'sd511,  1'b1, '{1'b0, 8'd0, 9'sd0, 9'sd0, 1'b1}};
    plan[7]  = '{REQ_SET,    8'd1,   -10'sd512, 1'b1, '{1'b0, 8'd1, HIDDEN, 9'sd0, 1'b0}};
    plan[8]  = '{REQ_SET,    8'd1,   10'sd0,    1'b0, '0};
    plan[9]  = '{REQ_SET,    8'd2,   10'sd1,    1'b0, '0};
    plan[10] = '{REQ_SET,    8'd0,   10'sd511,  1'b0, '0};
    plan[11] = '{REQ_SET,    8'd0,   10'sd0,    1'b0, '0};
    plan[12] = '{REQ_SET,    8'd2,   -10'sd1,   1'b0, '0};
    plan[13] = '{REQ_SET,    8'd1,   10'sd1,    1'b0, '0};
    plan[14] = '{REQ_FREE,   8'd2,   10'sd0,    1'b0, '0};
    plan[15] = '{REQ_FREE,   8'd0,   10'sd0,    1'b0, '0};
    plan[16] = '{REQ_ALLOC,  8'd0,   10'sd0,    1'b0, '0};
    plan[17] = '{REQ_SET,    8'd3,   10'sd5,    1'b0, '0};
    plan[18] = '{REQ_FREE,   8'd1,   -10'sd1,   1'b0, '0};
    plan[19] = '{REQ_UNUSED, 8'd0,   10'sd0,    1'b0, '0};
    plan[20] = '{REQ_ALLOC,  8'd0,   10'sd0,    1'b0, '0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      offer_word(plan[i].req, plan[i].id, plan[i].want, plan[i].typed, plan[i].report);
    end

    // mixed traffic on a partly used pool
    repeat (150) begin
      r = $urandom_range(99);
      if (r < 30) offer_word(REQ_ALLOC, LAYER_W'($urandom_range(255)), pick_height());
      else if (r < 70) offer_word(REQ_SET, pick_busy(), pick_height());
      else if (r < 80) offer_word(REQ_FREE, pick_busy(), pick_height());
      else if (r < 86) offer_word(REQ_SET, LAYER_W'($urandom_range(255)), pick_height());
      else if (r < 92) offer_word(REQ_FREE, LAYER_W'($urandom_range(255)), pick_height());
      else offer_word(REQ_UNUSED, LAYER_W'($urandom_range(255)),
                      WANT_W'($urandom_range(1023)));
    end
    drain_reports();

    // fill the pool with no idling, show every layer, then ask for more
    no_idle = 1'b1;
    slot_i = lowest_free();
    while (slot_i >= 0) begin
      offer_word(REQ_ALLOC, LAYER_W'($urandom_range(255)), pick_height());
      if ($urandom_range(99) < 85) offer_word(REQ_SET, slot_i[LAYER_W-1:0], pick_height());
      slot_i = lowest_free();
    end
    for (int k = 0; k < LAYERS; k++) begin
      if (lyr_height[k] < 0) offer_word(REQ_SET, k[LAYER_W-1:0], WANT_W'($urandom_range(511)));
    end
    repeat (3) offer_word(REQ_ALLOC, LAYER_W'($urandom_range(255)), pick_height());
    repeat (6) offer_word(REQ_SET, pick_busy(), pick_height());
    no_idle = 1'b0;
    drain_reports();

    // long receiver hold while requests keep coming, then teardown traffic
    hold_asked++;
    repeat (150) begin
      r = $urandom_range(99);
      if (r < 35) offer_word(REQ_FREE, pick_busy(), pick_height());
      else if (r < 75) offer_word(REQ_SET, pick_busy(), pick_height());
      else if (r < 85) offer_word(REQ_ALLOC, LAYER_W'($urandom_range(255)), pick_height());
      else if (r < 92) offer_word(REQ_SET, LAYER_W'($urandom_range(255)), pick_height());
      else offer_word(REQ_UNUSED, LAYER_W'($urandom_range(255)),
                      WANT_W'($urandom_range(1023)));
    end
    drain_reports();

    repeat (300) @(posedge clk);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side: random stalls, one long hold, check at the falling edge
  initial begin
    stack_report_t exp_rep;
    int hold_cnt;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done < hold_asked) begin
        hold_done++;
        out_stall <= 1'b1;
        hold_cnt = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(posedge clk);
          hold_cnt++;
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("unexpected word: layer %0d", out_result_layer);
          errors++;
        end else begin
          exp_rep = reports_due.pop_front();
          if (out_status !== exp_rep.status) begin
            $error("status: expected %0d, actual %0d", exp_rep.status, out_status);
            errors++;
          end
          if (out_result_layer !== exp_rep.layer) begin
            $error("result_layer: expected %0d, actual %0d", exp_rep.layer, out_result_layer);
            errors++;
          end
          if (out_applied_height !== exp_rep.applied) begin
            $error("applied_height: expected %0d, actual %0d",
                   $signed(exp_rep.applied), $signed(out_applied_height));
            errors++;
          end
          if (out_top_index !== exp_rep.top) begin
            $error("top_index: expected %0d, actual %0d",
                   $signed(exp_rep.top), $signed(out_top_index));
            errors++;
          end
          if (out_redraw_needed !== exp_rep.redraw) begin
            $error("redraw_needed: expected %0d, actual %0d", exp_rep.redraw,
                   out_redraw_needed);
            errors++;
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

endmodule
